### src/plin_pkg.sv
// shared constants and result type for the linear11 converter
package plin_pkg;

    localparam int unsigned WORD_W  = 16;
    localparam int unsigned FLOAT_W = 32;
    localparam int unsigned EXP_W   = 5;
    localparam int unsigned MANT_W  = 11;

    localparam logic KIND_DECODE = 1'b0;
    localparam logic KIND_ENCODE = 1'b1;

    localparam logic [MANT_W-1:0] MANT_POS_MAX = 11'h3FF;
    localparam logic [MANT_W-1:0] MANT_NEG_MAX = 11'h400;

    typedef struct packed {
        logic [FLOAT_W-1:0] decoded_value;
        logic [WORD_W-1:0]  encoded_word;
        logic               range_flag;
    } result_t;

endpackage

### src/plin_decode.sv
// linear11 word to single precision decode
module plin_decode
    import plin_pkg::*;
(
    input  logic [WORD_W-1:0]  word,
    output logic [FLOAT_W-1:0] value
);
    logic signed [EXP_W-1:0]  e;
    logic signed [MANT_W-1:0] m;
    logic [MANT_W-2:0]        mag;
    logic [3:0]               p;
    logic [7:0]               biased;
    logic [22:0]              frac;
    logic [MANT_W-1:0]        negm;

    always_comb begin
        e    = word[15:11];
        m    = word[10:0];
        negm = 11'(-m);
        // magnitude of -1024 is 1024, which needs bit 10
        mag  = m[10] ? negm[9:0] : m[9:0];
        p    = 4'd0;
        for (int i = 1; i <= 10; i++) begin
            if (i == 10) begin
                if (m == 11'sh400) p = 4'd10;
            end else if (mag[i]) begin
                p = 4'(i);
            end
        end
        biased = 8'(8'd127 + {4'd0, p} + {{3{e[4]}}, e});
        frac   = m == 11'sh400 ? 23'd0 : 23'({13'd0, mag} << (5'd23 - {1'b0, p}));
        if (m == 11'sd0) value = '0;
        else value = {m[10], biased, frac};
    end
endmodule

### src/plin_encode.sv
// single precision to linear11 word encode
module plin_encode
    import plin_pkg::*;
(
    input  logic [FLOAT_W-1:0] fbits,
    input  logic [EXP_W-1:0]   code,
    output logic [WORD_W-1:0]  word,
    output logic               flag
);
    logic               neg;
    logic [7:0]         bexp;
    logic [23:0]        sig;
    logic signed [9:0]  sh;
    logic [23:0]        mag;
    logic               sat;
    logic [MANT_W-1:0]  mant;

    always_comb begin
        neg  = fbits[31];
        bexp = fbits[30:23];
        sig  = {1'b1, fbits[22:0]};
        sh   = 10'(signed'({2'b0, bexp}) - 10'sd150 - signed'({{5{code[4]}}, code}));
        mag  = '0;
        sat  = 1'b0;
        flag = 1'b0;
        mant = '0;
        if (bexp == 8'hFF) begin
            flag = 1'b1;
            if (fbits[22:0] != 23'd0) mant = '0;
            else mant = neg ? MANT_NEG_MAX : MANT_POS_MAX;
        end else begin
            if (bexp != 8'd0) begin
                if (sh >= 0) sat = 1'b1;
                else if (sh > -10'sd24) mag = sig >> 5'(-sh);
            end
            if (!sat) sat = neg ? (mag > 24'd1024) : (mag > 24'd1023);
            if (sat) begin
                flag = 1'b1;
                mant = neg ? MANT_NEG_MAX : MANT_POS_MAX;
            end else begin
                mant = neg ? 11'(-mag[10:0]) : mag[10:0];
            end
        end
        word = {code, mant};
    end
endmodule

### src/pmbus_linear11_float_converter_core.sv
// pmbus linear11 / single precision converter top level
// path: each item passes through the input register and then the result register before its result transfer
// throughput: one item per cycle, no stalls beyond output back-pressure
// the two register stages form a pipeline that advances whenever the next stage frees
// reset: synchronous active-low aresetn clears both valid flags; payload is not reset
module pmbus_linear11_float_converter_core
    import plin_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [WORD_W-1:0]  s_linear_word,
    input  logic [FLOAT_W-1:0] s_float_value,
    input  logic [EXP_W-1:0]   s_exponent_code,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [FLOAT_W-1:0] m_decoded_value,
    output logic [WORD_W-1:0]  m_encoded_word,
    output logic               m_range_flag
);
    logic               in_valid_reg;
    logic               in_kind_reg;
    logic [WORD_W-1:0]  in_word_reg;
    logic [FLOAT_W-1:0] in_float_reg;
    logic [EXP_W-1:0]   in_code_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    result_t            res_next;
    logic [FLOAT_W-1:0] dec_value;
    logic [WORD_W-1:0]  enc_word;
    logic               enc_flag;
    logic               out_free;
    logic               in_free;

    plin_decode u_dec (.word(in_word_reg), .value(dec_value));
    plin_encode u_enc (.fbits(in_float_reg), .code(in_code_reg),
                       .word(enc_word), .flag(enc_flag));

    assign out_free = !out_valid_reg || m_ready;
    assign in_free  = !in_valid_reg || out_free;
    assign s_ready  = in_free;

    always_comb begin
        res_next = '0;
        if (in_kind_reg == KIND_ENCODE) begin
            res_next.encoded_word = enc_word;
            res_next.range_flag   = enc_flag;
        end else begin
            res_next.decoded_value = dec_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_free) in_valid_reg <= s_valid;
            if (out_free) out_valid_reg <= in_valid_reg;
        end
        if (in_free && s_valid) begin
            in_kind_reg  <= s_kind;
            in_word_reg  <= s_linear_word;
            in_float_reg <= s_float_value;
            in_code_reg  <= s_exponent_code;
        end
        if (out_free && in_valid_reg) out_reg <= res_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_decoded_value = out_reg.decoded_value;
    assign m_encoded_word  = out_reg.encoded_word;
    assign m_range_flag    = out_reg.range_flag;
endmodule
